// ===== rtl/checkpoint_table_validator_macros.svh =====
// Assertion macros used by the checkpoint table validator checker.
`ifndef CHECKPOINT_TABLE_VALIDATOR_MACROS_SVH
`define CHECKPOINT_TABLE_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CTV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("checkpoint table validator assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CTV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("checkpoint table validator assertion failed");

`endif

// ===== rtl/ctv_pkg.sv =====
// Shared types and constants of the checkpoint table validator.
package ctv_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int HASH_W      = 256;

   localparam logic [15:0] UNLOCK_WINDOW_RESET = 16'd10;
   localparam logic [0:0]  REG_UNLOCK_WINDOW   = 1'b0;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              op;
      logic [31:0]       blk_height;
      logic [31:0]       chain_height;
      logic [HASH_W-1:0] hash;
   } item_type;

   typedef struct packed {
      logic [1:0] insert_status;
      logic       is_checkpoint;
      logic       hash_ok;
      logic       in_zone;
      logic       alt_allowed;
   } result_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [IDX_W-1:0]  raddr;
      logic [31:0]       wheight;
      logic [HASH_W-1:0] whash;
   } ram_req_type;

endpackage

// ===== rtl/ctv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ctv_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ctv_ctrl.sv =====
// Sequencer that scans the checkpoint memories and forms one result per request.
module ctv_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  ctv_pkg::item_type            item,
   input  logic [15:0]                  unlock_window,
   output logic                         res_valid,
   input  logic                         res_ready,
   output ctv_pkg::result_type          res,
   output ctv_pkg::ram_req_type         ram,
   input  logic [31:0]                  height_rdata,
   input  logic [ctv_pkg::HASH_W-1:0]   hash_rdata
);

   ctv_pkg::state_type          state_ff, state_in;
   ctv_pkg::item_type           item_ff, item_in;
   logic [ctv_pkg::CNT_W-1:0]   issue_ff, issue_in;
   logic                        pend_ff, pend_in;
   logic                        matched_ff, matched_in;
   logic                        hash_eq_ff, hash_eq_in;
   logic                        pfound_ff, pfound_in;
   logic [31:0]                 best_ff, best_in;
   logic [ctv_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [31:0]                 top_ff, top_in;

   logic                        is_query;
   logic                        zone;
   logic [31:0]                 floor_height;
   logic                        alt;
   logic                        full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctv_pkg::S_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      issue_ff   <= issue_in;
      matched_ff <= matched_in;
      hash_eq_ff <= hash_eq_in;
      pfound_ff  <= pfound_in;
      best_ff    <= best_in;
   end

   // Query answers, valid once the scan has drained.
   assign is_query     = (item_ff.op == ctv_pkg::OP_QUERY);
   assign zone         = (count_ff != '0) && (item_ff.blk_height <= top_ff);
   assign floor_height = item_ff.chain_height - {16'd0, unlock_window};
   assign full         = (count_ff >= ctv_pkg::CNT_W'(ctv_pkg::MAX_ENTRIES));

   always_comb begin
      priority if (item_ff.blk_height == 32'd0) begin
         alt = 1'b0;
      end else if ((item_ff.blk_height < floor_height) && !zone) begin
         alt = 1'b0;
      end else begin
         alt = !pfound_ff || (best_ff < item_ff.blk_height);
      end
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      issue_in   = issue_ff;
      pend_in    = 1'b0;
      matched_in = matched_ff;
      hash_eq_in = hash_eq_ff;
      pfound_in  = pfound_ff;
      best_in    = best_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      item_ready = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      ram.we      = 1'b0;
      ram.waddr   = count_ff[ctv_pkg::IDX_W-1:0];
      ram.raddr   = issue_ff[ctv_pkg::IDX_W-1:0];
      ram.wheight = item_ff.blk_height;
      ram.whash   = item_ff.hash;

      // Compare the entry whose read data arrives this cycle.
      if (pend_ff) begin
         if (height_rdata == item_ff.blk_height) begin
            matched_in = 1'b1;
            hash_eq_in = (hash_rdata == item_ff.hash);
         end
         if ((height_rdata <= item_ff.chain_height) &&
             (!pfound_ff || (height_rdata > best_ff))) begin
            pfound_in = 1'b1;
            best_in   = height_rdata;
         end
      end

      unique case (state_ff)
         ctv_pkg::S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               item_in    = item;
               issue_in   = '0;
               matched_in = 1'b0;
               hash_eq_in = 1'b0;
               pfound_in  = 1'b0;
               best_in    = '0;
               state_in   = ctv_pkg::S_SCAN;
            end
         end
         ctv_pkg::S_SCAN: begin
            if (issue_ff < count_ff) begin
               pend_in  = 1'b1;
               issue_in = issue_ff + ctv_pkg::CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = ctv_pkg::S_DONE;
            end
         end
         ctv_pkg::S_DONE: begin
            if (is_query) begin
               res.insert_status = ctv_pkg::ST_OK;
               res.is_checkpoint = matched_ff;
               res.hash_ok       = !matched_ff || hash_eq_ff;
               res.in_zone       = zone;
               res.alt_allowed   = alt;
            end else if (matched_ff) begin
               res.insert_status = ctv_pkg::ST_DUP;
            end else if (full) begin
               res.insert_status = ctv_pkg::ST_FULL;
            end else begin
               res.insert_status = ctv_pkg::ST_OK;
            end
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = ctv_pkg::S_IDLE;
               if (!is_query && !matched_ff && !full) begin
                  ram.we   = 1'b1;
                  count_in = count_ff + ctv_pkg::CNT_W'(1);
                  if ((count_ff == '0) || (item_ff.blk_height > top_ff)) begin
                     top_in = item_ff.blk_height;
                  end
               end
            end
         end
         default: begin
            state_in = ctv_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/checkpoint_table_validator.sv =====
// Top level of the checkpoint table validator: register port, memories, result register.
//
// The block keeps up to MAX_ENTRIES checkpoints (a 32-bit height with a 256-bit hash).
// A request on the req_ channel either inserts a checkpoint (opcode 0) or queries a
// block (opcode 1); every request gives exactly one result on the rsp_ channel.
// An insert reports ok, height already present, or table full. A query reports
// whether the height is a checkpoint, whether its hash agrees, whether it lies in
// the checkpoint zone, and whether an alternative block is allowed.
// Heights and hashes live in two synchronous memories. Each request walks the
// stored entries once through the memory read port, one entry per cycle. Requests
// are handled one at a time. The result sits in an output register; the next
// request is accepted while it waits, and the scan stalls at its end only if the
// previous result is still held by the receiver. unlock_window is written through
// the APB-style port and should only change while the block is idle.
// Reset empties the table at once (the fill count goes to zero; memory contents
// are left as they are) and sets unlock_window back to 10.
module checkpoint_table_validator (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_blk_height,
   input  logic [31:0] req_chain_height,
   input  logic [63:0] req_hash_word0,
   input  logic [63:0] req_hash_word1,
   input  logic [63:0] req_hash_word2,
   input  logic [63:0] req_hash_word3,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_insert_status,
   output logic        rsp_is_checkpoint,
   output logic        rsp_hash_ok,
   output logic        rsp_in_zone,
   output logic        rsp_alt_allowed,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0]                   window_ff, window_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ctv_pkg::result_type           rsp_ff, rsp_in;

   ctv_pkg::item_type             item;
   ctv_pkg::result_type           res;
   logic                          res_valid;
   logic                          res_ready;
   ctv_pkg::ram_req_type          ram;
   logic [31:0]                   height_rdata;
   logic [ctv_pkg::HASH_W-1:0]    hash_rdata;
   logic                          reg_hit;

   // Register port: one register, selected by the word address bit.
   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == ctv_pkg::REG_UNLOCK_WINDOW);
   assign prdata  = reg_hit ? {16'd0, window_ff} : 32'd0;

   always_comb begin
      window_in = window_ff;
      if (psel && penable && pwrite && reg_hit) begin
         window_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= ctv_pkg::UNLOCK_WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The hash words are kept as one 256-bit row per entry, word 0 lowest.
   assign item.op           = req_opcode;
   assign item.blk_height   = req_blk_height;
   assign item.chain_height = req_chain_height;
   assign item.hash         = {req_hash_word3, req_hash_word2, req_hash_word1, req_hash_word0};

   ctv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_valid),
      .item_ready    (req_ready),
      .item          (item),
      .unlock_window (window_ff),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res),
      .ram           (ram),
      .height_rdata  (height_rdata),
      .hash_rdata    (hash_rdata)
   );

   ctv_ram #(
      .WIDTH (32),
      .DEPTH (ctv_pkg::MAX_ENTRIES)
   ) u_height_ram (
      .clock (clock),
      .we    (ram.we),
      .waddr (ram.waddr),
      .wdata (ram.wheight),
      .raddr (ram.raddr),
      .rdata (height_rdata)
   );

   ctv_ram #(
      .WIDTH (ctv_pkg::HASH_W),
      .DEPTH (ctv_pkg::MAX_ENTRIES)
   ) u_hash_ram (
      .clock (clock),
      .we    (ram.we),
      .waddr (ram.waddr),
      .wdata (ram.whash),
      .raddr (ram.raddr),
      .rdata (hash_rdata)
   );

   // Output register: the sequencer hands over a result only when it is free
   // or being emptied in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_insert_status = rsp_ff.insert_status;
   assign rsp_is_checkpoint = rsp_ff.is_checkpoint;
   assign rsp_hash_ok       = rsp_ff.hash_ok;
   assign rsp_in_zone       = rsp_ff.in_zone;
   assign rsp_alt_allowed   = rsp_ff.alt_allowed;

endmodule

// ===== rtl/ctv_checker.sv =====
// Port-level checker for the checkpoint table validator and its bind.
`include "checkpoint_table_validator_macros.svh"

module ctv_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_insert_status,
   input logic       rsp_is_checkpoint,
   input logic       rsp_hash_ok,
   input logic       rsp_in_zone
);

   // A stalled result keeps its valid and its status.
   `CTV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_insert_status))

   // Only the three defined status codes ever appear.
   `CTV_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_insert_status == ctv_pkg::ST_OK || rsp_insert_status == ctv_pkg::ST_DUP || rsp_insert_status == ctv_pkg::ST_FULL)

   // A refused insert carries no query answers.
   `CTV_ASSERT_NOW(a_refused_clean, clock, reset, rsp_valid && rsp_insert_status != ctv_pkg::ST_OK, !rsp_is_checkpoint && !rsp_hash_ok && !rsp_in_zone)

   // A checkpoint height can never lie above the highest checkpoint.
   `CTV_ASSERT_NOW(a_cp_in_zone, clock, reset, rsp_valid && rsp_is_checkpoint, rsp_in_zone)

endmodule

bind checkpoint_table_validator ctv_checker u_ctv_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_insert_status (rsp_insert_status),
   .rsp_is_checkpoint (rsp_is_checkpoint),
   .rsp_hash_ok       (rsp_hash_ok),
   .rsp_in_zone       (rsp_in_zone)
);
